// ----- hw/rtl/ssds_pkg.sv -----
// Shared types, constants and lookup functions for the seven-segment digit serializer.
package ssds_pkg;

   localparam int VALUE_WIDTH = 14;
   localparam int FRAME_BITS = 16;
   localparam int COUNT_WIDTH = 4;
   localparam int RECIP_WIDTH = 24;
   localparam int RECIP_SHIFT = 23;
   localparam int TENTH_WIDTH = 10;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = 14'd9999;
   localparam logic [7:0] SELECT_BASE = 8'h08;
   localparam logic [15:0] TENTH_RECIP = 16'd52429;
   localparam int TENTH_SHIFT = 19;

   localparam logic CSR_VALUE_HIGH = 1'b0;
   localparam logic CSR_VALUE_LOW = 1'b1;

   localparam logic [1:0] POS_THOUSANDS = 2'd0;
   localparam logic [1:0] POS_HUNDREDS = 2'd1;
   localparam logic [1:0] POS_TENS = 2'd2;
   localparam logic [1:0] POS_UNITS = 2'd3;

   typedef struct packed {
      logic disp;
      logic blank;
      logic [FRAME_BITS-1:0] frame;
   } frame_type;

   // Active-low segment pattern, gfedcba order.
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0: pat = 8'hC0;
         4'd1: pat = 8'hF9;
         4'd2: pat = 8'hA4;
         4'd3: pat = 8'hB0;
         4'd4: pat = 8'h99;
         4'd5: pat = 8'h92;
         4'd6: pat = 8'h82;
         4'd7: pat = 8'hF8;
         4'd8: pat = 8'h80;
         4'd9: pat = 8'h90;
         default: pat = 8'hFF;
      endcase
      return pat;
   endfunction

   // 2^23 / 10^(3-pos), rounded up; exact floor for values up to 9999.
   function automatic logic [RECIP_WIDTH-1:0] scale_recip(input logic [1:0] pos);
      logic [RECIP_WIDTH-1:0] r;
      case (pos)
         POS_THOUSANDS: r = 24'd8389;
         POS_HUNDREDS: r = 24'd83887;
         POS_TENS: r = 24'd838861;
         POS_UNITS: r = 24'd8388608;
         default: r = 24'd8388608;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/ssds_digit_pipe.sv -----
// Three-stage digit extraction and frame build: scale, split off tens, pattern lookup.
module ssds_digit_pipe import ssds_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic in_disp,
   input  logic [1:0] in_pos,
   input  logic [VALUE_WIDTH-1:0] in_value,
   output logic out_valid,
   input  logic out_ready,
   output frame_type out_frame
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_disp_ff, s2_disp_ff, s3_disp_ff;
   logic [1:0] s1_pos_ff, s2_pos_ff, s3_pos_ff;
   logic [VALUE_WIDTH-1:0] s1_value_ff;
   logic [VALUE_WIDTH-1:0] s2_scaled_ff, s3_scaled_ff;
   logic [TENTH_WIDTH-1:0] s3_tenths_ff;

   logic s1_ready, s2_ready, s3_ready;
   logic [VALUE_WIDTH-1:0] s1_value_in, s2_scaled_in;
   logic [TENTH_WIDTH-1:0] s3_tenths_in;
   logic [VALUE_WIDTH+RECIP_WIDTH-1:0] scale_prod;
   logic [VALUE_WIDTH+15:0] tenth_prod;
   logic [VALUE_WIDTH-1:0] ten_times, digit_wide;
   logic [3:0] digit;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_value_in = (in_value > VALUE_MAX) ? VALUE_MAX : in_value;

   assign scale_prod = (VALUE_WIDTH+RECIP_WIDTH)'(s1_value_ff)
                     * (VALUE_WIDTH+RECIP_WIDTH)'(scale_recip(s1_pos_ff));
   assign s2_scaled_in = scale_prod[RECIP_SHIFT +: VALUE_WIDTH];

   assign tenth_prod = (VALUE_WIDTH+16)'(s2_scaled_ff) * (VALUE_WIDTH+16)'(TENTH_RECIP);
   assign s3_tenths_in = tenth_prod[TENTH_SHIFT +: TENTH_WIDTH];

   assign ten_times = VALUE_WIDTH'({s3_tenths_ff, 3'b000}) + VALUE_WIDTH'({s3_tenths_ff, 1'b0});
   assign digit_wide = s3_scaled_ff - ten_times;
   assign digit = digit_wide[3:0];

   assign out_valid = s3_valid_ff;
   assign out_frame.disp = s3_disp_ff;
   assign out_frame.blank = (s3_pos_ff == POS_THOUSANDS) && (digit == 4'd0);
   assign out_frame.frame = {seg_pattern(digit), SELECT_BASE >> s3_pos_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_disp_ff <= in_disp;
         s1_pos_ff <= in_pos;
         s1_value_ff <= s1_value_in;
      end
      if (s2_ready) begin
         s2_disp_ff <= s1_disp_ff;
         s2_pos_ff <= s1_pos_ff;
         s2_scaled_ff <= s2_scaled_in;
      end
      if (s3_ready) begin
         s3_disp_ff <= s2_disp_ff;
         s3_pos_ff <= s2_pos_ff;
         s3_scaled_ff <= s2_scaled_ff;
         s3_tenths_ff <= s3_tenths_in;
      end
   end

endmodule

// ----- hw/rtl/seven_segment_digit_serializer.sv -----
// Top level: display value registers, digit pipeline and 16-bit frame serializer.
//
//  channel | direction | tdata / data              | tuser / index    | tlast
//  --------+-----------+---------------------------+------------------+------------
//  req_    | in        | [1:0] digit_position      | target_display   | -
//  rsp_    | out       | [3:0] bit_index,[4] serial | display_select   | latch_after
//  csr_    | in        | [13:0] value              | 0 high, 1 low    | -
//
// A request transaction is registered in stages s1, s2 and s3 before it
// reaches the serializer. Each frame then streams 16 response transactions,
// one per cycle while rsp_tready is high; the one-bit response port sets the rate.
// Requests for a blank thousands digit produce no responses and are dropped.
// Up to three requests queue in the pipeline while a frame is streaming.
// Reset is synchronous and clears the value registers and all valid flags.
module seven_segment_digit_serializer import ssds_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [1:0] digit_position, [7:2] zero
   input  logic req_tuser,         // [0] target_display
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] bit_index, [4] serial_data, [7:5] zero
   output logic rsp_tuser,         // [0] display_select
   output logic rsp_tlast,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [VALUE_WIDTH-1:0] csr_data
);

   logic [VALUE_WIDTH-1:0] value_high_ff, value_low_ff;
   logic ser_valid_ff, ser_disp_ff;
   logic [FRAME_BITS-1:0] ser_frame_ff;
   logic [COUNT_WIDTH-1:0] ser_count_ff;

   logic pipe_valid, pipe_ready, ser_load, ser_done;
   frame_type pipe_frame;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_high_ff <= '0;
         value_low_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VALUE_HIGH: value_high_ff <= csr_data;
            CSR_VALUE_LOW: value_low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ssds_digit_pipe u_digit_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_disp   (req_tuser),
      .in_pos    (req_tdata[1:0]),
      .in_value  (req_tuser ? value_low_ff : value_high_ff),
      .out_valid (pipe_valid),
      .out_ready (pipe_ready),
      .out_frame (pipe_frame)
   );

   assign ser_done = rsp_tvalid && rsp_tready && rsp_tlast;
   assign pipe_ready = pipe_frame.blank || !ser_valid_ff || ser_done;
   assign ser_load = pipe_valid && !pipe_frame.blank && (!ser_valid_ff || ser_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
      end else if (ser_load) begin
         ser_valid_ff <= 1'b1;
      end else if (ser_done) begin
         ser_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_disp_ff <= pipe_frame.disp;
         ser_frame_ff <= pipe_frame.frame;
         ser_count_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         ser_frame_ff <= {ser_frame_ff[FRAME_BITS-2:0], 1'b0};
         ser_count_ff <= ser_count_ff + 1'b1;
      end
   end

   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tdata = {3'b000, ser_frame_ff[FRAME_BITS-1], ser_count_ff};
   assign rsp_tuser = ser_disp_ff;
   assign rsp_tlast = (ser_count_ff == COUNT_WIDTH'(FRAME_BITS - 1));

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast)
      |=> (rsp_tvalid && ser_count_ff == $past(ser_count_ff) + 1'b1))
      else $error("serializer count did not advance");

   a_select_onehot: assert property (@(posedge clock) disable iff (reset)
      ser_load |=> ($onehot(ser_frame_ff[3:0]) && ser_frame_ff[7:4] == 4'h0
                    && ser_count_ff == '0))
      else $error("loaded frame has a bad digit-select byte");

   a_frame_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(ser_frame_ff) && $stable(ser_count_ff)))
      else $error("frame moved while response stalled");

   a_no_load_midframe: assert property (@(posedge clock) disable iff (reset)
      (ser_load && ser_valid_ff) |-> ser_done)
      else $error("frame overwritten before its last bit was taken");

endmodule
